// File: rtl/pem_pkg.sv
// Shared types and constants for the Prewitt edge magnitude core.
package pem_pkg;
  localparam int unsigned PixW  = 10;
  localparam int unsigned GradW = 13;
  localparam int unsigned MagW  = 11;
  localparam int unsigned CwW   = 11;
  localparam int unsigned ChW   = 13;
  localparam int unsigned SqW   = 23;
  localparam int unsigned RootW = 12;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    last;
  } grad_t;

  typedef struct packed {
    logic [GradW-1:0] row_gradient;
    logic [GradW-1:0] column_gradient;
    logic [MagW-1:0]  edge_magnitude;
    logic             last_of_frame;
  } result_t;
endpackage

// File: rtl/prewitt_edge_magnitude_core.sv
// Prewitt edge magnitude core: front end, gradient queue, back end, result queue.
// Throughput: one pixel per cycle while the result queue has room.
// Reset: counters and window clear; line buffers are undefined until written.
// Widths reset to 640 by 480.
module prewitt_edge_magnitude_core #(
  parameter int unsigned MaxWidth = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic                        flush_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pem_pkg::GradW-1:0]   row_gradient_o,
  output logic [pem_pkg::GradW-1:0]   column_gradient_o,
  output logic [pem_pkg::MagW-1:0]    edge_magnitude_o,
  output logic                        last_of_frame_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [12:0]                 cfg_data_i
);
  import pem_pkg::*;
  localparam int unsigned OutDepth = 32;

  logic [CwW-1:0] width_q;
  logic [ChW-1:0] height_q;
  logic           f_valid, q_empty, b_valid, take;
  grad_t          f_grad, q_grad;
  result_t        b_res, o_res;
  logic [2:0]     q_cnt;
  logic [5:0]     o_cnt;
  logic [5:0]     pend_q;
  logic           accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CwW'(640);
      height_q <= ChW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_data_i[CwW-1:0];
        CfgHeight: height_q <= cfg_data_i[ChW-1:0];
        default:   ;
      endcase
    end
  end

  assign accept = push && !full;
  assign take   = !q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 6'(take) - 6'(b_valid);
    end
  end

  assign full = (7'(o_cnt) + 7'(pend_q) + 7'(q_cnt) + 7'(f_valid)) >= 7'(OutDepth);

  pem_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i, .rst_ni, .valid_i(accept), .red_i, .green_i, .blue_i, .flush_i,
    .width_i(width_q), .height_i(height_q), .valid_o(f_valid), .grad_o(f_grad)
  );

  pem_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_grad), .count_o(q_cnt),
    .pop_i(take), .empty_o(q_empty), .data_o(q_grad)
  );

  pem_back u_back (
    .clk_i, .rst_ni, .valid_i(take), .grad_i(q_grad),
    .valid_o(b_valid), .res_o(b_res)
  );

  pem_out_fifo #(.Depth(OutDepth)) u_out (
    .clk_i, .rst_ni, .push_i(b_valid), .data_i(b_res), .pop_i(pop && !empty),
    .empty_o(empty), .count_o(o_cnt), .data_o(o_res)
  );

  assign row_gradient_o    = o_res.row_gradient;
  assign column_gradient_o = o_res.column_gradient;
  assign edge_magnitude_o  = o_res.edge_magnitude;
  assign last_of_frame_o   = o_res.last_of_frame;
endmodule

// File: rtl/pem_front.sv
// Front end: line buffers, 3x3 window and Prewitt gradients, one pixel per cycle.
module pem_front #(
  parameter int unsigned MaxWidth = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [7:0]              red_i,
  input  logic [7:0]              green_i,
  input  logic [7:0]              blue_i,
  input  logic                    flush_i,
  input  logic [pem_pkg::CwW-1:0] width_i,
  input  logic [pem_pkg::ChW-1:0] height_i,
  output logic                    valid_o,
  output pem_pkg::grad_t          grad_o
);
  import pem_pkg::*;
  localparam int unsigned AW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CntW = $clog2(MaxWidth + 1);

  logic [PixW-1:0] buf1_mem [MaxWidth];
  logic [PixW-1:0] buf2_mem [MaxWidth];
  logic [PixW-1:0] rd1_q, rd2_q;
  logic [PixW-1:0] win_q [3][3];
  logic [PixW-1:0] win_d [3][3];
  logic [PixW-1:0] win_n [3][3];
  logic [CntW-1:0] col_q, col_d;
  logic [ChW:0]    row_q, row_d;
  logic            valid_q;
  grad_t           grad_q;

  logic [CntW-1:0] w_eff, c_eff;
  logic [ChW:0]    h_eff;
  logic [PixW-1:0] px, top, mid, rd1, rd2;
  logic [AW-1:0]   ra;
  logic            emit, last;
  logic signed [GradW-1:0] gx, gy;

  always_comb begin
    w_eff = (width_i == '0) ? CntW'(1) :
            ((32'(width_i) > MaxWidth) ? CntW'(MaxWidth) : CntW'(width_i));
    h_eff = (height_i == '0) ? (ChW+1)'(1) : (ChW+1)'(height_i);
    c_eff = (32'(col_q) >= MaxWidth) ? '0 : col_q;
    px = '0;
    if (!flush_i && row_q < h_eff) begin
      px = PixW'(red_i) + PixW'(green_i) + PixW'(blue_i);
    end
    rd1 = rd1_q;
    rd2 = rd2_q;
    top = (row_q >= 2) ? rd2 : '0;
    mid = (row_q >= 1) ? rd1 : '0;
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = (c_eff == '0) ? '0 : top;
    win_d[1][2] = (c_eff == '0) ? '0 : mid;
    win_d[2][2] = (c_eff == '0) ? '0 : px;
    emit = (c_eff == '0) ? (row_q >= 2) : (row_q >= 1);
    last = (c_eff == '0) && (row_q >= h_eff + 1);
    gx = '0;
    gy = '0;
    for (int k = 0; k < 3; k++) begin
      gx = gx + $signed({3'b0, win_d[2][k]}) - $signed({3'b0, win_d[0][k]});
      gy = gy + $signed({3'b0, win_d[k][0]}) - $signed({3'b0, win_d[k][2]});
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last) begin
      row_d = '0;
      col_d = '0;
    end else if ((c_eff + 1'b1) >= w_eff) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = c_eff + 1'b1;
    end
    ra = valid_i ? col_d[AW-1:0] : c_eff[AW-1:0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_n[i][j] = last ? '0 : win_d[i][j];
      end
    end
    if (c_eff == '0 && !last) begin
      for (int i = 0; i < 3; i++) begin
        win_n[i][0] = '0;
        win_n[i][1] = '0;
      end
      win_n[0][2] = top;
      win_n[1][2] = mid;
      win_n[2][2] = px;
    end
  end

  // The line buffers are read ahead, at the column of the next request.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      buf2_mem[c_eff[AW-1:0]] <= rd1;
      buf1_mem[c_eff[AW-1:0]] <= px;
    end
    if (valid_i && ra == c_eff[AW-1:0]) begin
      rd1_q <= px;
      rd2_q <= rd1;
    end else begin
      rd1_q <= buf1_mem[ra];
      rd2_q <= buf2_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      valid_q <= valid_i && emit;
      if (valid_i) begin
        col_q <= col_d;
        row_q <= row_d;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            win_q[i][j] <= win_n[i][j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      grad_q.gx   <= gx;
      grad_q.gy   <= gy;
      grad_q.last <= last;
    end
  end

  assign valid_o = valid_q;
  assign grad_o  = grad_q;
endmodule

// File: rtl/pem_queue.sv
// Small queue of gradient records between the front and back ends.
module pem_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pem_pkg::grad_t data_i,
  output logic [$clog2(Depth+1)-1:0] count_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pem_pkg::grad_t data_o
);
  import pem_pkg::*;
  localparam int unsigned AW = $clog2(Depth);
  grad_t            mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;
endmodule

// File: rtl/pem_back.sv
// Back end: magnitude by a pipelined square root and divide by three.
module pem_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  pem_pkg::grad_t   grad_i,
  output logic             valid_o,
  output pem_pkg::result_t res_o
);
  import pem_pkg::*;
  localparam int unsigned Steps = RootW;

  logic             sq_v_q;
  logic [SqW-1:0]   sq_q;
  grad_t            sq_g_q;
  logic             v_q [Steps+1];
  logic [SqW-1:0]   rem_q [Steps+1];
  logic [RootW-1:0] root_q [Steps+1];
  grad_t            g_q [Steps+1];
  logic             out_v_q;
  result_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= Steps; i++) v_q[i] <= 1'b0;
    end else begin
      sq_v_q <= valid_i;
      v_q[0] <= sq_v_q;
      for (int i = 1; i <= Steps; i++) v_q[i] <= v_q[i-1];
      out_v_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= SqW'(grad_i.gx * grad_i.gx) + SqW'(grad_i.gy * grad_i.gy);
    sq_g_q <= grad_i;
    rem_q[0]  <= sq_q;
    root_q[0] <= '0;
    g_q[0]    <= sq_g_q;
    for (int i = 0; i < Steps; i++) begin
      logic [SqW+1:0] trial;
      logic [SqW+1:0] remw;
      remw  = {2'b0, rem_q[i]} >> (2 * (Steps - 1 - i));
      trial = {root_q[i], 2'b01};
      if (remw >= trial) begin
        rem_q[i+1]  <= rem_q[i] - SqW'(trial << (2 * (Steps - 1 - i)));
        root_q[i+1] <= {root_q[i][RootW-2:0], 1'b1};
      end else begin
        rem_q[i+1]  <= rem_q[i];
        root_q[i+1] <= {root_q[i][RootW-2:0], 1'b0};
      end
      g_q[i+1] <= g_q[i];
    end
    out_q.row_gradient    <= g_q[Steps].gx;
    out_q.column_gradient <= g_q[Steps].gy;
    out_q.edge_magnitude  <= MagW'((26'(root_q[Steps]) * 26'd5462) >> 14);
    out_q.last_of_frame   <= g_q[Steps].last;
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;
endmodule

// File: rtl/pem_out_fifo.sv
// Output queue holding finished results until they are popped.
module pem_out_fifo #(
  parameter int unsigned Depth = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pem_pkg::result_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output pem_pkg::result_t data_o
);
  import pem_pkg::*;
  localparam int unsigned AW = $clog2(Depth);
  result_t       mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rp_q];
endmodule
